>>> src/amps_pkg.sv
// Shared types, constants and the micro-program of the moment propagation step.
`timescale 1ns / 1ps
package amps_pkg;

   localparam int WORD_BITS     = 48;
   localparam int FRAC_BITS     = 24;
   localparam int NUM_MOMENTS   = 15;
   localparam int NUM_NOISE     = 9;
   localparam int RAM_DEPTH     = 32;
   localparam int RAM_ADDR_BITS = 5;
   localparam int OPND_BITS     = 6;
   localparam int PC_BITS       = 8;
   localparam int PROG_DEPTH    = 256;
   localparam int CHUNK_BITS    = 16;

   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_STEP = 1'b1;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic       opcode;
      logic [3:0] load_index;
      word_type   load_value;
      word_type   speed_noise_mean;
      word_type   speed_noise_second;
      word_type   cos_mean;
      word_type   cos_second;
      word_type   sin_mean;
      word_type   sin_second;
      word_type   cos_sin_mean;
      word_type   turn_cos_mean;
      word_type   turn_sin_mean;
   } req_type;

   typedef struct packed {
      logic [3:0] moment_index;
      word_type   moment_value;
      logic       last_flag;
   } rsp_type;

   typedef enum logic [1:0] {
      U_ADD = 2'd0,
      U_SUB = 2'd1,
      U_MUL = 2'd2,
      U_END = 2'd3
   } uop_kind_type;

   typedef struct packed {
      uop_kind_type               kind;
      logic [OPND_BITS-1:0]       a;
      logic [OPND_BITS-1:0]       b;
      logic [RAM_ADDR_BITS-1:0]   d;
   } uop_type;

   // Operand map: stored moments, new moments, temporaries, noise inputs, zero
   localparam logic [OPND_BITS-1:0] A_V    = 6'd0;
   localparam logic [OPND_BITS-1:0] A_V2   = 6'd1;
   localparam logic [OPND_BITS-1:0] A_XS   = 6'd2;
   localparam logic [OPND_BITS-1:0] A_YS   = 6'd3;
   localparam logic [OPND_BITS-1:0] A_XC   = 6'd4;
   localparam logic [OPND_BITS-1:0] A_YC   = 6'd5;
   localparam logic [OPND_BITS-1:0] A_XVS  = 6'd6;
   localparam logic [OPND_BITS-1:0] A_XVC  = 6'd7;
   localparam logic [OPND_BITS-1:0] A_YVS  = 6'd8;
   localparam logic [OPND_BITS-1:0] A_YVC  = 6'd9;
   localparam logic [OPND_BITS-1:0] A_X    = 6'd10;
   localparam logic [OPND_BITS-1:0] A_Y    = 6'd11;
   localparam logic [OPND_BITS-1:0] A_XY   = 6'd12;
   localparam logic [OPND_BITS-1:0] A_X2   = 6'd13;
   localparam logic [OPND_BITS-1:0] A_Y2   = 6'd14;
   localparam logic [OPND_BITS-1:0] A_N0   = 6'd15;
   localparam logic [OPND_BITS-1:0] A_T0   = 6'd30;
   localparam logic [OPND_BITS-1:0] A_T1   = 6'd31;
   localparam logic [OPND_BITS-1:0] A_WV   = 6'd32;
   localparam logic [OPND_BITS-1:0] A_WV2  = 6'd33;
   localparam logic [OPND_BITS-1:0] A_C    = 6'd34;
   localparam logic [OPND_BITS-1:0] A_C2   = 6'd35;
   localparam logic [OPND_BITS-1:0] A_S    = 6'd36;
   localparam logic [OPND_BITS-1:0] A_S2   = 6'd37;
   localparam logic [OPND_BITS-1:0] A_CS   = 6'd38;
   localparam logic [OPND_BITS-1:0] A_CW   = 6'd39;
   localparam logic [OPND_BITS-1:0] A_SW   = 6'd40;
   localparam logic [OPND_BITS-1:0] A_ZERO = 6'd41;

   function automatic uop_type mk(input uop_kind_type kind, input logic [OPND_BITS-1:0] d,
                                  input logic [OPND_BITS-1:0] a,
                                  input logic [OPND_BITS-1:0] b);
      uop_type u;
      u.kind = kind;
      u.a    = a;
      u.b    = b;
      u.d    = d[RAM_ADDR_BITS-1:0];
      return u;
   endfunction

   function automatic logic [OPND_BITS-1:0] nw(input int k);
      return A_N0 + OPND_BITS'(k);
   endfunction

   // Micro-program: T0 accumulates, T1 carries product chains
   function automatic uop_type prog_at(input logic [PC_BITS-1:0] pc);
      uop_type p [PROG_DEPTH];
      int      n;
      for (int i = 0; i < PROG_DEPTH; i++) p[i] = mk(U_END, A_T0, A_ZERO, A_ZERO);
      n = 0;
      // new speed mean
      p[n] = mk(U_ADD, nw(0), A_V, A_WV); n++;
      // new speed second moment
      p[n] = mk(U_ADD, A_T1, A_V, A_V); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_WV); n++;
      p[n] = mk(U_ADD, A_T0, A_V2, A_T1); n++;
      p[n] = mk(U_ADD, nw(1), A_T0, A_WV2); n++;
      // xs
      p[n] = mk(U_MUL, A_T0, A_V, A_CS); n++;
      p[n] = mk(U_MUL, A_T0, A_T0, A_CW); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_SW); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_C2); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XS, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XC, A_SW); n++;
      p[n] = mk(U_ADD, nw(2), A_T0, A_T1); n++;
      // ys
      p[n] = mk(U_MUL, A_T0, A_V, A_S2); n++;
      p[n] = mk(U_MUL, A_T0, A_T0, A_CW); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_SW); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CS); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YS, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YC, A_SW); n++;
      p[n] = mk(U_ADD, nw(3), A_T0, A_T1); n++;
      // xc
      p[n] = mk(U_MUL, A_T1, A_V, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_ZERO, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_C2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XS, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XC, A_CW); n++;
      p[n] = mk(U_ADD, nw(4), A_T0, A_T1); n++;
      // yc
      p[n] = mk(U_MUL, A_T1, A_V, A_S2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_ZERO, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YS, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YC, A_CW); n++;
      p[n] = mk(U_ADD, nw(5), A_T0, A_T1); n++;
      // xvs
      p[n] = mk(U_MUL, A_T0, A_V2, A_CS); n++;
      p[n] = mk(U_MUL, A_T0, A_T0, A_CW); n++;
      p[n] = mk(U_MUL, A_T1, A_V2, A_SW); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_C2); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_C2); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XVS, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XVC, A_SW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_XS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_XC); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_ADD, nw(6), A_T0, A_T1); n++;
      // xvc
      p[n] = mk(U_MUL, A_T1, A_V2, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_ZERO, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V2, A_C2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_C2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XVS, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_XVC, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_XS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_XC); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, nw(7), A_T0, A_T1); n++;
      // yvs
      p[n] = mk(U_MUL, A_T0, A_V2, A_S2); n++;
      p[n] = mk(U_MUL, A_T0, A_T0, A_CW); n++;
      p[n] = mk(U_MUL, A_T1, A_V2, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_S2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YVS, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YVC, A_SW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_YS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_YC); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_ADD, nw(8), A_T0, A_T1); n++;
      // yvc
      p[n] = mk(U_MUL, A_T1, A_V2, A_S2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_ZERO, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V2, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_S2); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_WV); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YVS, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_YVC, A_CW); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_YS); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_SW); n++;
      p[n] = mk(U_SUB, A_T0, A_T0, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_WV, A_YC); n++;
      p[n] = mk(U_MUL, A_T1, A_T1, A_CW); n++;
      p[n] = mk(U_ADD, nw(9), A_T0, A_T1); n++;
      // positions
      p[n] = mk(U_MUL, A_T1, A_V, A_C); n++;
      p[n] = mk(U_ADD, nw(10), A_X, A_T1); n++;
      p[n] = mk(U_MUL, A_T1, A_V, A_S); n++;
      p[n] = mk(U_ADD, nw(11), A_Y, A_T1); n++;
      // xy
      p[n] = mk(U_MUL, A_T1, A_V2, A_CS); n++;
      p[n] = mk(U_ADD, A_T0, A_T1, A_XVS); n++;
      p[n] = mk(U_ADD, A_T0, A_T0, A_YVC); n++;
      p[n] = mk(U_ADD, nw(12), A_T0, A_XY); n++;
      // x squared
      p[n] = mk(U_MUL, A_T1, A_V2, A_C2); n++;
      p[n] = mk(U_ADD, A_T0, A_XVC, A_XVC); n++;
      p[n] = mk(U_ADD, A_T0, A_T1, A_T0); n++;
      p[n] = mk(U_ADD, nw(13), A_T0, A_X2); n++;
      // y squared
      p[n] = mk(U_MUL, A_T1, A_V2, A_S2); n++;
      p[n] = mk(U_ADD, A_T0, A_YVS, A_YVS); n++;
      p[n] = mk(U_ADD, A_T0, A_T1, A_T0); n++;
      p[n] = mk(U_ADD, nw(14), A_T0, A_Y2); n++;
      return p[pc];
   endfunction

endpackage

>>> src/agent_moment_propagation_step.sv
// Top level: moment propagation step on a shared multiply/add unit under a micro-sequencer.
// Load transaction: writes one stored moment, no response.
// Step transaction: 153 micro-ops; an add passes RDA, RDB and EXEC, a multiply RDA, RDB, EXEC,
// one MUL pass per 16-bit chunk and RND; then 15 responses, each through ERD, EOUT and EWAIT.
// One transaction at a time; the shared multiply unit and the single RAM read port set the rate.
// Synchronous active-high reset clears the stored moments (valid bits) and the sequencer.
`timescale 1ns / 1ps
module agent_moment_propagation_step #(
   parameter int FRAC_BITS = amps_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  amps_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output amps_pkg::rsp_type rsp_payload
);

   localparam int W        = amps_pkg::WORD_BITS;
   localparam int CH       = amps_pkg::CHUNK_BITS;
   localparam int NCH      = (W + CH - 1) / CH;
   localparam int PADW     = NCH * CH;
   localparam int ACC_W    = W + PADW;
   localparam int CNT_BITS = $clog2(NCH + 1);
   localparam int AB       = amps_pkg::RAM_ADDR_BITS;
   localparam int OB       = amps_pkg::OPND_BITS;
   localparam int NM       = amps_pkg::NUM_MOMENTS;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RDA   = 9'b000000010,
      S_RDB   = 9'b000000100,
      S_EXEC  = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_RND   = 9'b000100000,
      S_ERD   = 9'b001000000,
      S_EOUT  = 9'b010000000,
      S_EWAIT = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      SRC_RAM  = 2'd0,
      SRC_INP  = 2'd1,
      SRC_ZERO = 2'd2
   } src_type;

   state_type                   state_ff, state_in;
   logic [amps_pkg::PC_BITS-1:0] pc_ff, pc_in;
   logic [3:0]                  k_ff, k_in;
   logic [NM-1:0]               valid_ff, valid_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   src_type                     src_ff, src_in;
   logic                        ok_ff, ok_in;
   logic [3:0]                  nidx_ff, nidx_in;
   amps_pkg::word_type          noise_ff [amps_pkg::NUM_NOISE];
   amps_pkg::word_type          opa_ff;
   logic [W-1:0]                mag_a_ff;
   logic [PADW-1:0]             mag_b_ff;
   logic                        neg_ff;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   amps_pkg::rsp_type           rsp_ff;

   amps_pkg::uop_type           uop;
   amps_pkg::word_type          opnd;
   logic                        req_acc, rsp_acc;
   logic [OB-1:0]               rd_opnd;
   logic                        rd_en;
   logic                        ram_we;
   logic [AB-1:0]               ram_waddr, ram_raddr;
   amps_pkg::word_type          ram_wdata, ram_rdata;
   logic signed [W:0]           sum_ext;
   amps_pkg::word_type          addsub_res;
   logic [ACC_W-1:0]            rnd_sum, rnd_q, rnd_lim;
   logic [W-1:0]                rnd_mag;
   amps_pkg::word_type          mul_res;
   logic [W-1:0]                mag_a_w, mag_b_w;
   logic [W+CH-1:0]             part_prod;
   logic [OB-1:0]               nidx_full;
   logic [AB-1:0]               emit_addr;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign uop = amps_pkg::prog_at(pc_ff);
   assign emit_addr = amps_pkg::A_N0[AB-1:0] + AB'(k_ff);

   amps_ram #(
      .WIDTH(W),
      .DEPTH(amps_pkg::RAM_DEPTH)
   ) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // select the operand fetched last cycle
   always_comb begin
      unique case (src_ff)
         SRC_RAM:  opnd = ok_ff ? ram_rdata : '0;
         SRC_INP:  opnd = noise_ff[nidx_ff];
         default:  opnd = '0;
      endcase
   end

   // classify the operand being fetched this cycle
   always_comb begin
      rd_opnd = (state_ff == S_RDB) ? uop.b : uop.a;
      rd_en = (state_ff == S_RDA) || (state_ff == S_RDB);
      nidx_full = rd_opnd - amps_pkg::A_WV;
      ram_raddr = (state_ff == S_ERD) ? emit_addr : rd_opnd[AB-1:0];
      src_in = src_ff;
      ok_in = ok_ff;
      nidx_in = nidx_ff;
      if (rd_en) begin
         nidx_in = nidx_full[3:0];
         ok_in = (rd_opnd >= amps_pkg::A_N0) || valid_ff[rd_opnd[3:0]];
         priority if (rd_opnd < amps_pkg::A_WV) begin
            src_in = SRC_RAM;
         end else if (rd_opnd < amps_pkg::A_ZERO) begin
            src_in = SRC_INP;
         end else begin
            src_in = SRC_ZERO;
         end
      end else if (state_ff == S_ERD) begin
         src_in = SRC_RAM;
         ok_in = 1'b1;
      end
   end

   // saturating add and subtract
   always_comb begin
      if (uop.kind == amps_pkg::U_SUB) begin
         sum_ext = {opa_ff[W-1], opa_ff} - {opnd[W-1], opnd};
      end else begin
         sum_ext = {opa_ff[W-1], opa_ff} + {opnd[W-1], opnd};
      end
      if (sum_ext[W] != sum_ext[W-1]) begin
         addsub_res = sum_ext[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         addsub_res = sum_ext[W-1:0];
      end
   end

   // round the magnitude product to nearest, ties away from zero, then saturate
   always_comb begin
      rnd_sum = acc_ff + (ACC_W'(1) << (FRAC_BITS - 1));
      rnd_q = rnd_sum >> FRAC_BITS;
      rnd_lim = neg_ff ? (ACC_W'(1) << (W - 1)) : ((ACC_W'(1) << (W - 1)) - ACC_W'(1));
      rnd_mag = (rnd_q > rnd_lim) ? rnd_lim[W-1:0] : rnd_q[W-1:0];
      mul_res = neg_ff ? -rnd_mag : rnd_mag;
   end

   assign mag_a_w = opa_ff[W-1] ? -opa_ff : opa_ff;
   assign mag_b_w = opnd[W-1] ? -opnd : opnd;
   assign part_prod = mag_a_ff * mag_b_ff[PADW-1 -: CH];
   assign acc_in = (acc_ff << CH) + ACC_W'(part_prod);

   // RAM write port
   always_comb begin
      ram_we = 1'b0;
      ram_waddr = uop.d;
      ram_wdata = addsub_res;
      unique case (state_ff)
         S_IDLE: begin
            ram_we = req_acc && (req_payload.opcode == amps_pkg::OPC_LOAD)
                     && (req_payload.load_index < 4'(NM));
            ram_waddr = AB'(req_payload.load_index);
            ram_wdata = req_payload.load_value;
         end
         S_EXEC: begin
            ram_we = (uop.kind == amps_pkg::U_ADD) || (uop.kind == amps_pkg::U_SUB);
         end
         S_RND: begin
            ram_we = 1'b1;
            ram_wdata = mul_res;
         end
         S_EOUT: begin
            ram_we = 1'b1;
            ram_waddr = AB'(k_ff);
            ram_wdata = opnd;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_payload.opcode == amps_pkg::OPC_STEP) begin
                  state_in = S_RDA;
                  pc_in = '0;
               end else if (req_payload.load_index < 4'(NM)) begin
                  valid_in[req_payload.load_index] = 1'b1;
               end
            end
         end
         S_RDA: begin
            if (uop.kind == amps_pkg::U_END) begin
               state_in = S_ERD;
               k_in = '0;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cnt_in = '0;
            if (uop.kind == amps_pkg::U_MUL) begin
               state_in = S_MUL;
            end else begin
               state_in = S_RDA;
               pc_in = pc_ff + 1'b1;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(NCH - 1)) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            state_in = S_RDA;
            pc_in = pc_ff + 1'b1;
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            valid_in[k_ff] = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (k_ff == 4'(NM - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= '0;
         k_ff <= '0;
         cnt_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         src_ff <= SRC_ZERO;
         ok_ff <= 1'b0;
         nidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         k_ff <= k_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         src_ff <= src_in;
         ok_ff <= ok_in;
         nidx_ff <= nidx_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_acc) begin
         noise_ff[0] <= req_payload.speed_noise_mean;
         noise_ff[1] <= req_payload.speed_noise_second;
         noise_ff[2] <= req_payload.cos_mean;
         noise_ff[3] <= req_payload.cos_second;
         noise_ff[4] <= req_payload.sin_mean;
         noise_ff[5] <= req_payload.sin_second;
         noise_ff[6] <= req_payload.cos_sin_mean;
         noise_ff[7] <= req_payload.turn_cos_mean;
         noise_ff[8] <= req_payload.turn_sin_mean;
      end
      if (state_ff == S_RDB) begin
         opa_ff <= opnd;
      end
      if (state_ff == S_EXEC) begin
         mag_a_ff <= mag_a_w;
         mag_b_ff <= PADW'(mag_b_w);
         neg_ff <= opa_ff[W-1] ^ opnd[W-1];
         acc_ff <= '0;
      end
      if (state_ff == S_MUL) begin
         acc_ff <= acc_in;
         mag_b_ff <= mag_b_ff << CH;
      end
      if (state_ff == S_EOUT) begin
         rsp_ff.moment_index <= k_ff;
         rsp_ff.moment_value <= opnd;
         rsp_ff.last_flag <= (k_ff == 4'(NM - 1));
      end
   end

   // checks
   a_rsp_only_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_EWAIT)
      else $error("response valid outside emit wait");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_flag) |-> rsp_payload.moment_index == 4'(NM - 1))
      else $error("last flag on wrong index");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_payload.last_flag) |=> state_ff == S_IDLE)
      else $error("sequencer not idle after last response");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> cnt_ff < CNT_BITS'(NCH))
      else $error("multiply chunk counter overrun");

endmodule

>>> src/amps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module amps_ram #(
   parameter int WIDTH = amps_pkg::WORD_BITS,
   parameter int DEPTH = amps_pkg::RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
